// File: src/ewh_pkg.sv
package ewh_pkg;

  localparam int SAMP_W     = 16;
  localparam int KIND_W     = 2;
  localparam int BIN_W      = 6;
  localparam int CNT_W      = 13;
  localparam int FREQ_W     = 17;
  localparam int FRAC_W     = 16;
  localparam int ROOT_W     = 18;
  localparam int AUTO_SPLIT = 100;

  localparam logic [FREQ_W-1:0] Q_ONE = 17'h10000;

  localparam logic OP_LOAD  = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  localparam logic [KIND_W-1:0] KIND_ROW   = 2'd0;
  localparam logic [KIND_W-1:0] KIND_QUERY = 2'd1;
  localparam logic [KIND_W-1:0] KIND_EMPTY = 2'd2;

  typedef struct packed {
    logic               operation;
    logic signed [SAMP_W-1:0] sample_value;
    logic               last_sample;
  } in_item_t;

  typedef struct packed {
    logic [KIND_W-1:0] result_kind;
    logic [BIN_W-1:0]  bin_index;
    logic [CNT_W-1:0]  bin_count;
    logic [CNT_W-1:0]  cumulative_count;
    logic [FREQ_W-1:0] relative_freq;
    logic [FREQ_W-1:0] cumulative_freq;
    logic [CNT_W-1:0]  max_count;
    logic [FREQ_W-1:0] max_relative_freq;
    logic [BIN_W-1:0]  class_count;
    logic              last_of_run;
  } out_item_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

// File: src/ewh_div.sv
module ewh_div #(
  parameter int DW = 29,
  parameter int VW = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic [DW-1:0]       dividend,
  input  logic [VW-1:0]       divisor,
  output logic [DW-1:0]       quotient,
  output ewh_pkg::div_stat_t  stat
);
  import ewh_pkg::*;

  localparam int CNTW = $clog2(DW + 1);

  logic [DW-1:0]   quo_r;
  logic [VW-1:0]   rem_r;
  logic [VW-1:0]   dvs_r;
  logic [CNTW-1:0] cnt_r;
  logic            busy_r;
  logic            done_r;
  logic [VW:0]     trial_nxt;
  logic            fits_nxt;

  // restoring division, one quotient bit per cycle
  assign trial_nxt = {rem_r, quo_r[DW-1]};
  assign fits_nxt  = (trial_nxt >= {1'b0, dvs_r});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start && !busy_r) begin
        busy_r <= 1'b1;
        cnt_r  <= CNTW'(DW);
        quo_r  <= dividend;
        rem_r  <= '0;
        dvs_r  <= divisor;
      end else if (busy_r) begin
        rem_r <= fits_nxt ? VW'(trial_nxt - {1'b0, dvs_r}) : trial_nxt[VW-1:0];
        quo_r <= {quo_r[DW-2:0], fits_nxt};
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CNTW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign quotient  = quo_r;
  assign stat.busy = busy_r;
  assign stat.done = done_r;

`ifndef SYNTHESIS
  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy_r |=> busy_r) else $error("divider did not start");
  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> !busy_r && $past(busy_r)) else $error("done without a run");
  a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |=> !done_r) else $error("done held");
`endif

endmodule

// File: src/equal_width_histogram_engine_top.sv
// channel | ports                          | accepted when
// input   | start, busy, in_item           | start && !busy
// result  | out_valid, out_item            | every cycle out_valid is high
// config  | cfg_valid, cfg_ready, cfg_data | cfg_valid && cfg_ready
//
// Plain loads are taken back to back. A load marked last starts a build on the
// shared serial divider (width DW, 29 at defaults), which yields one bit a cycle.
// A query is answered in the next cycle before a build or outside [min, max].
// Reset is synchronous; bin counts are swept clear at each build, not at reset.
// Results are one-cycle strobes; the receiver cannot stall them.
module equal_width_histogram_engine_top #(
  parameter int MAX_SAMPLES = 4096,
  parameter int MAX_BINS    = 63
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  ewh_pkg::in_item_t   in_item,
  output logic                out_valid,
  output ewh_pkg::out_item_t  out_item,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [5:0]          cfg_data
);
  import ewh_pkg::*;

  localparam int CW   = $clog2(MAX_SAMPLES + 1);
  localparam int AW   = $clog2(MAX_SAMPLES);
  localparam int BI   = (MAX_BINS > 1) ? $clog2(MAX_BINS) : 1;
  localparam int DIVW = (CW + FRAC_W > 22) ? CW + FRAC_W : 22;
  localparam int VW   = (CW > SAMP_W) ? CW : SAMP_W;

  typedef enum logic [4:0] {
    S_IDLE, S_ROOT, S_CLEAR, S_SCAN, S_BIN_RD, S_BIN_LD, S_IDX, S_IDX_WAIT,
    S_CNT_RD, S_CNT_WR, S_MAX, S_MF_GO, S_MF_WAIT, S_RD, S_RF_GO, S_RF_WAIT,
    S_CF_GO, S_CF_WAIT
  } state_t;

  state_t state_r;

  logic [BIN_W-1:0]        req_r;
  logic [CW-1:0]           total_r;
  logic                    built_r;
  logic                    is_q_r;
  logic signed [SAMP_W-1:0] min_r, max_r, val_r;
  logic [BIN_W-1:0]        cc_r, bin_r, root_r;
  logic [ROOT_W-1:0]       sq_r, cu_r;
  logic [CW-1:0]           i_r, cum_r, mc_r, cntv_r, cumv_r;
  logic [FREQ_W-1:0]       mf_r, rf_r;
  logic                    out_valid_r;
  out_item_t               out_r;

  // memories
  logic signed [SAMP_W-1:0] smem [MAX_SAMPLES];
  logic [CW-1:0]           cmem [MAX_BINS];
  logic [CW-1:0]           umem [MAX_BINS];
  logic signed [SAMP_W-1:0] s_rd_r;
  logic [CW-1:0]           c_rd_r, u_rd_r;
  logic                    s_we, c_we, u_we;
  logic [AW-1:0]           s_waddr;
  logic [BI-1:0]           c_waddr, u_waddr;
  logic [CW-1:0]           c_wdata, u_wdata;

  // divider
  logic                    div_start;
  logic [DIVW-1:0]         div_dvd, div_q;
  logic [VW-1:0]           div_dvs;
  div_stat_t               div_stat;

  logic                    accept, do_load;
  logic [CW-1:0]           total_nxt;
  logic [SAMP_W-1:0]       range_nxt, diff_nxt;
  logic [21:0]             prod_nxt;
  logic [BIN_W-1:0]        bin_fix_nxt, cc_req_nxt, cc_auto_nxt, root_odd_nxt;
  logic [ROOT_W-1:0]       tot_ext;
  logic                    use_cube, root_go;

  assign accept    = start && !busy;
  assign busy      = (state_r != S_IDLE);
  assign cfg_ready = 1'b1;
  assign do_load   = accept && (in_item.operation == OP_LOAD);

  assign range_nxt = SAMP_W'({max_r[SAMP_W-1], max_r} - {min_r[SAMP_W-1], min_r});
  assign diff_nxt  = SAMP_W'({val_r[SAMP_W-1], val_r} - {min_r[SAMP_W-1], min_r});
  assign prod_nxt  = 22'(diff_nxt) * 22'(cc_r);
  assign bin_fix_nxt = (div_q >= DIVW'(cc_r)) ? cc_r - 1'b1 : div_q[BIN_W-1:0];

  assign cc_req_nxt = (req_r > BIN_W'(MAX_BINS)) ? BIN_W'(MAX_BINS) : req_r;
  // even root steps down, zero becomes one
  assign root_odd_nxt = root_r[0] ? root_r : ((root_r == '0) ? BIN_W'(1) : root_r - 1'b1);
  assign cc_auto_nxt  = (root_odd_nxt > BIN_W'(MAX_BINS)) ? BIN_W'(MAX_BINS) : root_odd_nxt;
  assign tot_ext  = ROOT_W'(total_r);
  assign use_cube = (tot_ext >= ROOT_W'(AUTO_SPLIT));
  assign root_go  = use_cube ? (cu_r <= tot_ext) : (sq_r <= tot_ext);

  always_comb begin
    if (built_r) total_nxt = CW'(1);
    else if (total_r < CW'(MAX_SAMPLES)) total_nxt = total_r + 1'b1;
    else total_nxt = total_r;
  end

  // memory ports
  assign s_we    = do_load && (built_r || total_r < CW'(MAX_SAMPLES));
  assign s_waddr = built_r ? '0 : total_r[AW-1:0];
  assign c_we    = (state_r == S_CLEAR) || (state_r == S_CNT_WR);
  assign c_waddr = bin_r[BI-1:0];
  assign c_wdata = (state_r == S_CLEAR) ? '0 : c_rd_r + 1'b1;
  assign u_we    = (state_r == S_MAX) && (bin_r != '0);
  assign u_waddr = BI'(bin_r - 1'b1);
  assign u_wdata = cum_r + c_rd_r;

  always_ff @(posedge clk) begin
    if (s_we) smem[s_waddr] <= in_item.sample_value;
    s_rd_r <= smem[i_r[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (c_we) cmem[c_waddr] <= c_wdata;
    c_rd_r <= cmem[bin_r[BI-1:0]];
  end

  always_ff @(posedge clk) begin
    if (u_we) umem[u_waddr] <= u_wdata;
    u_rd_r <= umem[bin_r[BI-1:0]];
  end

  always_comb begin
    div_start = 1'b0;
    div_dvd   = DIVW'({cntv_r, FRAC_W'(0)});
    div_dvs   = VW'(total_r);
    case (state_r)
      S_IDX: begin
        div_start = (range_nxt != '0);
        div_dvd   = DIVW'(prod_nxt);
        div_dvs   = VW'(range_nxt);
      end
      S_MF_GO: begin
        div_start = 1'b1;
        div_dvd   = DIVW'({mc_r, FRAC_W'(0)});
      end
      S_RF_GO: begin
        div_start = 1'b1;
        div_dvd   = DIVW'({c_rd_r, FRAC_W'(0)});
      end
      S_CF_GO: begin
        div_start = 1'b1;
        div_dvd   = DIVW'({cumv_r, FRAC_W'(0)});
      end
      default: ;
    endcase
  end

  ewh_div #(.DW(DIVW), .VW(VW)) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dvd),
    .divisor  (div_dvs),
    .quotient (div_q),
    .stat     (div_stat)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) req_r <= '0;
    else if (cfg_valid) req_r <= cfg_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      total_r     <= '0;
      built_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (do_load) begin
            total_r <= total_nxt;
            built_r <= 1'b0;
            if (in_item.last_sample) begin
              is_q_r <= 1'b0;
              bin_r  <= '0;
              root_r <= '0;
              sq_r   <= ROOT_W'(1);
              cu_r   <= ROOT_W'(1);
              if (req_r != '0) begin
                cc_r    <= cc_req_nxt;
                state_r <= S_CLEAR;
              end else begin
                state_r <= S_ROOT;
              end
            end
          end else if (accept) begin
            out_r.result_kind      <= KIND_QUERY;
            out_r.bin_index        <= '0;
            out_r.bin_count        <= '0;
            out_r.cumulative_count <= '0;
            out_r.max_count        <= CNT_W'(mc_r);
            out_r.max_relative_freq <= mf_r;
            out_r.class_count      <= cc_r;
            out_r.last_of_run      <= 1'b1;
            if (!built_r) begin
              out_r.result_kind       <= KIND_EMPTY;
              out_r.relative_freq     <= '0;
              out_r.cumulative_freq   <= '0;
              out_r.max_count         <= '0;
              out_r.max_relative_freq <= '0;
              out_r.class_count       <= '0;
              out_valid_r <= 1'b1;
            end else if (in_item.sample_value < min_r) begin
              out_r.relative_freq   <= '0;
              out_r.cumulative_freq <= '0;
              out_valid_r <= 1'b1;
            end else if (in_item.sample_value > max_r) begin
              out_r.relative_freq   <= Q_ONE;
              out_r.cumulative_freq <= Q_ONE;
              out_valid_r <= 1'b1;
            end else begin
              is_q_r  <= 1'b1;
              val_r   <= in_item.sample_value;
              state_r <= S_IDX;
            end
          end
        end
        S_ROOT: begin
          if (root_go) begin
            root_r <= root_r + 1'b1;
            sq_r   <= sq_r + ROOT_W'({root_r, 1'b0}) + ROOT_W'(3);
            cu_r   <= cu_r + sq_r + {sq_r[ROOT_W-2:0], 1'b0}
                      + ROOT_W'(3) * ROOT_W'(root_r + 1'b1) + ROOT_W'(1);
          end else begin
            cc_r    <= cc_auto_nxt;
            bin_r   <= '0;
            state_r <= S_CLEAR;
          end
        end
        S_CLEAR: begin
          if (bin_r == BIN_W'(MAX_BINS - 1)) begin
            i_r     <= '0;
            state_r <= S_SCAN;
          end else begin
            bin_r <= bin_r + 1'b1;
          end
        end
        S_SCAN: begin
          // s_rd_r holds sample i_r-1
          if (i_r == CW'(1)) begin
            min_r <= s_rd_r;
            max_r <= s_rd_r;
          end else if (i_r != '0) begin
            if (s_rd_r < min_r) min_r <= s_rd_r;
            if (s_rd_r > max_r) max_r <= s_rd_r;
          end
          if (i_r == total_r) begin
            i_r     <= '0;
            state_r <= S_BIN_RD;
          end else begin
            i_r <= i_r + 1'b1;
          end
        end
        S_BIN_RD: state_r <= S_BIN_LD;
        S_BIN_LD: begin
          val_r   <= s_rd_r;
          state_r <= S_IDX;
        end
        S_IDX: begin
          if (range_nxt == '0) begin
            bin_r   <= '0;
            state_r <= is_q_r ? S_RD : S_CNT_RD;
          end else begin
            state_r <= S_IDX_WAIT;
          end
        end
        S_IDX_WAIT: begin
          if (div_stat.done) begin
            bin_r   <= bin_fix_nxt;
            state_r <= is_q_r ? S_RD : S_CNT_RD;
          end
        end
        S_CNT_RD: state_r <= S_CNT_WR;
        S_CNT_WR: begin
          if (i_r + 1'b1 == total_r) begin
            bin_r   <= '0;
            cum_r   <= '0;
            mc_r    <= '0;
            state_r <= S_MAX;
          end else begin
            state_r <= S_BIN_RD;
          end
          i_r <= i_r + 1'b1;
        end
        S_MAX: begin
          // c_rd_r holds bin bin_r-1; running sum goes to the cumulative store
          if (bin_r != '0) begin
            cum_r <= u_wdata;
            if (c_rd_r > mc_r) mc_r <= c_rd_r;
          end
          if (bin_r == cc_r) state_r <= S_MF_GO;
          else bin_r <= bin_r + 1'b1;
        end
        S_MF_GO: state_r <= S_MF_WAIT;
        S_MF_WAIT: begin
          if (div_stat.done) begin
            mf_r    <= div_q[FREQ_W-1:0];
            bin_r   <= '0;
            state_r <= S_RD;
          end
        end
        S_RD: state_r <= S_RF_GO;
        S_RF_GO: begin
          cntv_r  <= c_rd_r;
          cumv_r  <= u_rd_r;
          state_r <= S_RF_WAIT;
        end
        S_RF_WAIT: begin
          if (div_stat.done) begin
            rf_r    <= div_q[FREQ_W-1:0];
            state_r <= S_CF_GO;
          end
        end
        S_CF_GO: state_r <= S_CF_WAIT;
        S_CF_WAIT: begin
          if (div_stat.done) begin
            out_valid_r             <= 1'b1;
            out_r.result_kind       <= is_q_r ? KIND_QUERY : KIND_ROW;
            out_r.bin_index         <= bin_r;
            out_r.bin_count         <= CNT_W'(cntv_r);
            out_r.cumulative_count  <= CNT_W'(cumv_r);
            out_r.relative_freq     <= rf_r;
            out_r.cumulative_freq   <= div_q[FREQ_W-1:0];
            out_r.max_count         <= CNT_W'(mc_r);
            out_r.max_relative_freq <= mf_r;
            out_r.class_count       <= cc_r;
            out_r.last_of_run       <= is_q_r || (bin_r == cc_r - 1'b1);
            if (is_q_r) begin
              state_r <= S_IDLE;
            end else if (bin_r == cc_r - 1'b1) begin
              built_r <= 1'b1;
              state_r <= S_IDLE;
            end else begin
              bin_r   <= bin_r + 1'b1;
              state_r <= S_RD;
            end
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_r;

`ifndef SYNTHESIS
  a_row_index: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.result_kind == KIND_ROW |-> out_item.bin_index < out_item.class_count)
    else $error("row index beyond class count");
  a_load_rate: assert property (@(posedge clk) disable iff (!rst_n)
    accept && in_item.operation == OP_LOAD && !in_item.last_sample |=> !busy)
    else $error("plain load stalled the input");
  a_last_mark: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_item.last_of_run || out_item.result_kind == KIND_ROW)
    else $error("query answer without last mark");
  a_div_wait: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_IDX_WAIT |-> div_stat.busy || div_stat.done)
    else $error("waiting on an idle divider");
`endif

endmodule
